### sv/ccs_pkg.sv
`default_nettype none

package ccs_pkg;

    // fixed widths of the item fields
    localparam int NODE_W  = 6;
    localparam int COUNT_W = 7;
    localparam int EDGE_W  = 2 * NODE_W;

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b000_0000_0001,
        ST_LOAD     = 11'b000_0000_0010,
        ST_SEEK     = 11'b000_0000_0100,
        ST_SEEK_CHK = 11'b000_0000_1000,
        ST_EMIT     = 11'b000_0001_0000,
        ST_START    = 11'b000_0010_0000,
        ST_POP      = 11'b000_0100_0000,
        ST_POP_CHK  = 11'b000_1000_0000,
        ST_POP_VIS  = 11'b001_0000_0000,
        ST_SCAN     = 11'b010_0000_0000,
        ST_FINAL    = 11'b100_0000_0000
    } ccs_state_t;

endpackage

`default_nettype wire

### sv/ccs_ram.sv
`default_nettype none

module ccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/connected_component_sizes.sv
// connected component sizes of an undirected graph
//
// input channel (in_valid / in_stall): one item per cycle while loading; an item
// with has_edge set stores the edge node_a - node_b, an item with last_edge set
// ends the graph and starts the search. in_stall stays high during the search,
// while results are handed out and during the clearing pass.
// output channel (out_valid / out_stall): one item per component found from
// nodes 1..node_count in ascending order, the final one with last_group set;
// a graph with no component gives a single item with empty_res set.
// configuration (cfg_valid / cfg_ready / node_count): always ready, written idle.
// timing: one cycle per item while loading. the search reads the visited bit of
// each candidate start node; one that starts a component hands out the previous
// result if any, seeds the walk stack, and its walk ends when the stack is found
// empty. each node popped from the walk stack is checked against the visited memory;
// an unvisited one adds a scan over the edge memory, one edge read per cycle
// pipelined through the visited memory; the edge read port sets this.
// reset and every finished graph start a clearing pass over the MAX_NODES entries
// of the visited memory, during which no input item is accepted.
// a stalled receiver holds the result register; the search then waits at the
// next result until it is taken.

`default_nettype none

module connected_component_sizes #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int STACK_DEPTH = 512
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // edge items
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        has_edge,
    input  wire logic [ccs_pkg::NODE_W-1:0]  node_a,
    input  wire logic [ccs_pkg::NODE_W-1:0]  node_b,
    input  wire logic                        last_edge,
    // component items
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [ccs_pkg::NODE_W-1:0]       start_node,
    output logic [ccs_pkg::COUNT_W-1:0]      member_count,
    output logic [ccs_pkg::NODE_W-1:0]       group_number,
    output logic                             last_group,
    output logic                             empty_res,
    output logic                             edges_dropped,
    // configuration
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [ccs_pkg::NODE_W-1:0]  node_count
);

    import ccs_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);                       // visited address
    localparam int CW  = $clog2(MAX_NODES + 1);                   // member count
    localparam int EW  = $clog2(MAX_EDGES + 1);                   // edge total
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1; // edge address
    localparam int LW  = $clog2(STACK_DEPTH + 1);                 // stack level
    localparam int SAW = $clog2(STACK_DEPTH);                     // stack address
    localparam int IW  = NODE_W + 1;                              // start node scan

    ccs_state_t state_reg, state_next;

    logic [NODE_W-1:0]  node_count_reg;
    logic [EW-1:0]      edge_total_reg, edge_total_next;
    logic               overflow_reg, overflow_next;
    logic [NW-1:0]      clr_reg, clr_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [NODE_W-1:0]  group_reg, group_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [LW-1:0]      level_reg, level_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;

    // edge scan pipeline: s1 = edge data back, s2 = visited data back
    logic [EW-1:0]      e_reg, e_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s2_valid_reg, s2_valid_next;
    logic [NODE_W-1:0]  s2_other_reg, s2_other_next;

    // finished component waiting until we know whether it is the last one
    logic               pend_valid_reg, pend_valid_next;
    logic [NODE_W-1:0]  pend_start_reg, pend_start_next;
    logic [CW-1:0]      pend_count_reg, pend_count_next;
    logic [NODE_W-1:0]  pend_group_reg, pend_group_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]  out_start_reg, out_start_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [NODE_W-1:0]  out_group_reg, out_group_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_drop_reg, out_drop_next;

    // memory ports
    logic               vis_we, vis_wdata, vis_rdata;
    logic [NW-1:0]      vis_waddr, vis_raddr;
    logic               edge_we;
    logic [EAW-1:0]     edge_waddr, edge_raddr;
    logic [EDGE_W-1:0]  edge_wdata, edge_rdata;
    logic               stk_we;
    logic [SAW-1:0]     stk_waddr, stk_raddr;
    logic [NODE_W-1:0]  stk_wdata, stk_rdata;

    logic               in_accept;
    logic               out_free;
    logic               edge_ok;
    logic [NODE_W-1:0]  edge_a, edge_b, other;
    logic               match;
    logic               push;

    ccs_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    ccs_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    ccs_ram #(.WIDTH(NODE_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // endpoints outside the node table are ignored without a flag
    assign edge_ok = has_edge && (32'(node_a) < MAX_NODES) && (32'(node_b) < MAX_NODES);

    // edge data from the scan: the endpoint on the far side of the current node
    assign edge_a = edge_rdata[NODE_W-1:0];
    assign edge_b = edge_rdata[EDGE_W-1:NODE_W];
    assign match  = (edge_a == cur_reg) || (edge_b == cur_reg);
    assign other  = (edge_a == cur_reg) ? edge_b : edge_a;

    // a push onto a full stack is skipped
    assign push = (state_reg == ST_SCAN) && s2_valid_reg && !vis_rdata
                  && (32'(level_reg) < STACK_DEPTH);

    // memory port selection
    always_comb
    begin
        vis_we     = 1'b0;
        vis_waddr  = clr_reg;
        vis_wdata  = 1'b0;
        vis_raddr  = NW'(cur_reg);
        edge_we    = in_accept && edge_ok && (32'(edge_total_reg) < MAX_EDGES);
        edge_waddr = edge_total_reg[EAW-1:0];
        edge_wdata = {node_b, node_a};
        edge_raddr = e_reg[EAW-1:0];
        stk_we     = push;
        stk_waddr  = level_reg[SAW-1:0];
        stk_wdata  = s2_other_reg;
        stk_raddr  = SAW'(level_reg - LW'(1));
        case (state_reg)
            ST_CLEAR:
            begin
                vis_we = 1'b1;
            end
            ST_SEEK:
            begin
                vis_raddr = NW'(i_reg);
            end
            ST_START:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = NODE_W'(i_reg);
            end
            ST_POP_CHK:
            begin
                vis_raddr = NW'(stk_rdata);
            end
            ST_POP_VIS:
            begin
                vis_we    = !vis_rdata;
                vis_waddr = NW'(cur_reg);
                vis_wdata = 1'b1;
            end
            ST_SCAN:
            begin
                vis_raddr = NW'(other);
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        overflow_next   = overflow_reg;
        clr_next        = clr_reg;
        i_next          = i_reg;
        group_next      = group_reg;
        count_next      = count_reg;
        level_next      = level_reg;
        cur_next        = cur_reg;
        e_next          = e_reg;
        s1_valid_next   = 1'b0;
        s2_valid_next   = 1'b0;
        s2_other_next   = other;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_count_next = pend_count_reg;
        pend_group_next = pend_group_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_start_next  = out_start_reg;
        out_count_next  = out_count_reg;
        out_group_next  = out_group_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_drop_next   = out_drop_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + NW'(1);
                if (clr_reg == NW'(MAX_NODES - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (edge_ok)
                    begin
                        if (32'(edge_total_reg) < MAX_EDGES)
                        begin
                            edge_total_next = edge_total_reg + EW'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    if (last_edge)
                    begin
                        i_next          = IW'(1);
                        group_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SEEK;
                    end
                end
            end
            ST_SEEK:
            begin
                if ((i_reg > {1'b0, node_count_reg}) || (32'(i_reg) >= MAX_NODES))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_SEEK_CHK;
                end
            end
            ST_SEEK_CHK:
            begin
                if (vis_rdata)
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_SEEK;
                end
                else if (pend_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            ST_EMIT:
            begin
                // another component follows, so the pending one is not the last
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_start_next  = pend_start_reg;
                    out_count_next  = COUNT_W'(pend_count_reg);
                    out_group_next  = pend_group_reg;
                    out_last_next   = 1'b0;
                    out_empty_next  = 1'b0;
                    out_drop_next   = overflow_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_START;
                end
            end
            ST_START:
            begin
                level_next = LW'(1);
                count_next = '0;
                group_next = group_reg + NODE_W'(1);
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (level_reg == '0)
                begin
                    pend_valid_next = 1'b1;
                    pend_start_next = NODE_W'(i_reg);
                    pend_count_next = count_reg;
                    pend_group_next = group_reg;
                    i_next          = i_reg + IW'(1);
                    state_next      = ST_SEEK;
                end
                else
                begin
                    level_next = level_reg - LW'(1);
                    state_next = ST_POP_CHK;
                end
            end
            ST_POP_CHK:
            begin
                cur_next   = stk_rdata;
                state_next = ST_POP_VIS;
            end
            ST_POP_VIS:
            begin
                if (vis_rdata)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    e_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (e_reg != edge_total_reg)
                begin
                    e_next        = e_reg + EW'(1);
                    s1_valid_next = 1'b1;
                end
                s2_valid_next = s1_valid_reg && match;
                if (push)
                begin
                    level_next = level_reg + LW'(1);
                end
                if ((e_reg == edge_total_reg) && !s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_POP;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_drop_next   = overflow_reg;
                    if (pend_valid_reg)
                    begin
                        out_start_next = pend_start_reg;
                        out_count_next = COUNT_W'(pend_count_reg);
                        out_group_next = pend_group_reg;
                        out_empty_next = 1'b0;
                    end
                    else
                    begin
                        out_start_next = '0;
                        out_count_next = '0;
                        out_group_next = '0;
                        out_empty_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    edge_total_next = '0;
                    overflow_next   = 1'b0;
                    level_next      = '0;
                    clr_next        = '0;
                    state_next      = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= '0;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            clr_reg        <= '0;
            i_reg          <= '0;
            group_reg      <= '0;
            count_reg      <= '0;
            level_reg      <= '0;
            e_reg          <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= node_count;
            end
            edge_total_reg <= edge_total_next;
            overflow_reg   <= overflow_next;
            clr_reg        <= clr_next;
            i_reg          <= i_next;
            group_reg      <= group_next;
            count_reg      <= count_next;
            level_reg      <= level_next;
            e_reg          <= e_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        s2_other_reg   <= s2_other_next;
        pend_start_reg <= pend_start_next;
        pend_count_reg <= pend_count_next;
        pend_group_reg <= pend_group_next;
        out_start_reg  <= out_start_next;
        out_count_reg  <= out_count_next;
        out_group_reg  <= out_group_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_drop_reg   <= out_drop_next;
    end

    assign out_valid     = out_valid_reg;
    assign start_node    = out_start_reg;
    assign member_count  = out_count_reg;
    assign group_number  = out_group_reg;
    assign last_group    = out_last_reg;
    assign empty_res     = out_empty_reg;
    assign edges_dropped = out_drop_reg;

    // walk stack never grows past its depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(level_reg) <= STACK_DEPTH)
        else $error("walk stack level beyond depth");

    // edge total never grows past the edge memory
    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_total_reg) <= MAX_EDGES)
        else $error("edge total beyond edge memory");

    // an empty result is the only and final item, with zero fields
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_res) |-> (last_group && (member_count == '0)
                                      && (group_number == '0) && (start_node == '0)))
        else $error("empty result with nonzero fields");

    // scan pipeline is drained before leaving the scan
    a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> (state_reg == ST_SCAN))
        else $error("edge scan pipeline busy outside the scan");

    // a result is only loaded in the emit or final state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && out_stall))
            |-> ((state_reg == ST_EMIT) || (state_reg == ST_FINAL)))
        else $error("result loaded outside emit");

endmodule

`default_nettype wire
